// ===== sv/rci_pkg.sv =====
// Shared types, constants and saturating helpers for the ray / cone intersection block.
// Used by rci_core and ray_cone_intersect; depends on nothing else.
`default_nettype none

package rci_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STEPS    = 48;
    localparam int DIV_STEPS     = 31;
    localparam int RW            = 96;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] LIM66   = 66'sh0_7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] REG_APEX_X = 2'd0;
    localparam logic [1:0] REG_APEX_Y = 2'd1;
    localparam logic [1:0] REG_APEX_Z = 2'd2;
    localparam logic [1:0] REG_SLOPE  = 2'd3;

    typedef struct packed {
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] origin_z;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_x;
    } ray_t;

    typedef struct packed {
        logic signed [31:0] apex_x;
        logic signed [31:0] apex_y;
        logic signed [31:0] apex_z;
        logic        [31:0] slope_factor;
    } cone_t;

    function automatic logic signed [65:0] sx(input logic signed [63:0] v);
        return $signed({{2{v[63]}}, v});
    endfunction

    function automatic logic signed [63:0] clamp66(input logic signed [65:0] v);
        if (v > LIM66)
            return SAT_MAX;
        else if (v < -LIM66)
            return -SAT_MAX;
        else
            return $signed(v[63:0]);
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic [127:0] mag, input logic neg);
        logic [63:0] m;
        m = (mag > {65'd0, {63{1'b1}}}) ? {1'b0, {63{1'b1}}} : mag[63:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

`default_nettype wire

// ===== sv/rci_core.sv =====
// Pipelined datapath: quadratic set-up, discriminant, square root and two root dividers.
// Depends on rci_pkg; instantiated by ray_cone_intersect.
`default_nettype none

module rci_core
    import rci_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire ray_t                 ray,
    input  wire cone_t                cone,
    output logic                      out_valid,
    output logic                      hit,
    output logic [DIV_STEPS-1:0]      distance
);

    localparam int LAT = 12 + SQRT_STEPS + DIV_STEPS + 2;

    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    assign out_valid = vld_reg[LAT-1];

    // stage 1: offsets from apex
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] d1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= 33'(ray.origin_x) - 33'(cone.apex_x);
            e1_reg[1] <= 33'(ray.origin_y) - 33'(cone.apex_y);
            e1_reg[2] <= 33'(ray.origin_z) - 33'(cone.apex_z);
            d1_reg[0] <= 33'(ray.dir_x);
            d1_reg[1] <= 33'(ray.dir_y);
            d1_reg[2] <= 33'(ray.dir_z);
        end
    end

    // stage 2: nine first-level products; y terms carry an inverted sign
    logic signed [32:0] opa [9];
    logic signed [32:0] opb [9];

    always_comb
    begin
        opa[0] = d1_reg[0]; opb[0] = d1_reg[0];
        opa[1] = d1_reg[2]; opb[1] = d1_reg[2];
        opa[2] = d1_reg[1]; opb[2] = d1_reg[1];
        opa[3] = d1_reg[0]; opb[3] = e1_reg[0];
        opa[4] = d1_reg[2]; opb[4] = e1_reg[2];
        opa[5] = d1_reg[1]; opb[5] = e1_reg[1];
        opa[6] = e1_reg[0]; opb[6] = e1_reg[0];
        opa[7] = e1_reg[2]; opb[7] = e1_reg[2];
        opa[8] = e1_reg[1]; opb[8] = e1_reg[1];
    end

    logic [65:0]        p2_reg  [9];
    logic               n2_reg  [9];
    logic [63:0]        lo3_reg [9];
    logic [63:0]        hi3_reg [9];
    logic               n3_reg  [9];
    logic signed [63:0] t4_reg  [9];

    for (genvar j = 0; j < 9; j++)
    begin : g_terms
        localparam bit YTERM = (j % 3) == 2;
        logic [63:0] m3;
        logic [31:0] s_eff;
        logic [95:0] sum4;

        assign m3    = 64'(p2_reg[j] >> FRAC_BITS);
        assign s_eff = YTERM ? (32'(1) << FRAC_BITS) : cone.slope_factor;
        assign sum4  = 96'(lo3_reg[j]) + (96'(hi3_reg[j]) << 32);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p2_reg[j]  <= 66'(mag33(opa[j])) * 66'(mag33(opb[j]));
                n2_reg[j]  <= (opa[j][32] ^ opb[j][32]) ^ YTERM;
                lo3_reg[j] <= {32'd0, m3[31:0]} * {32'd0, s_eff};
                hi3_reg[j] <= {32'd0, m3[63:32]} * {32'd0, s_eff};
                n3_reg[j]  <= n2_reg[j];
                t4_reg[j]  <= apply_sign(128'(sum4 >> FRAC_BITS), n3_reg[j]);
            end
        end
    end

    // stages 5 to 7: form a, b, c
    logic signed [63:0] a5_reg, b5_reg, c5_reg, ya5_reg, yb5_reg, yc5_reg;
    logic signed [63:0] a6_reg, b6_reg, c6_reg;
    logic signed [63:0] a7_reg, b7_reg, c7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a5_reg  <= clamp66(sx(t4_reg[0]) + sx(t4_reg[1]));
            b5_reg  <= clamp66(sx(t4_reg[3]) + sx(t4_reg[4]));
            c5_reg  <= clamp66(sx(t4_reg[6]) + sx(t4_reg[7]));
            ya5_reg <= t4_reg[2];
            yb5_reg <= t4_reg[5];
            yc5_reg <= t4_reg[8];
            a6_reg  <= clamp66(sx(a5_reg) + sx(ya5_reg));
            b6_reg  <= clamp66(sx(b5_reg) + sx(yb5_reg));
            c6_reg  <= clamp66(sx(c5_reg) + sx(yc5_reg));
            a7_reg  <= a6_reg;
            b7_reg  <= clamp66(sx(b6_reg) + sx(b6_reg));
            c7_reg  <= c6_reg;
        end
    end

    // stages 8 to 10: a*c and b*b from 32-bit partial products
    logic [63:0] ua, uc, ub;
    assign ua = mag64(a7_reg);
    assign uc = mag64(c7_reg);
    assign ub = mag64(b7_reg);

    logic [63:0]        pac8_reg [4];
    logic [63:0]        pbb8_reg [4];
    logic               nac8_reg;
    logic signed [63:0] a8_reg, b8_reg;
    logic [127:0]       sac9_reg, sbb9_reg;
    logic               nac9_reg;
    logic signed [63:0] a9_reg, b9_reg;
    logic signed [63:0] ac10_reg, bb10_reg, a10_reg, b10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pac8_reg[0] <= {32'd0, ua[31:0]}  * {32'd0, uc[31:0]};
            pac8_reg[1] <= {32'd0, ua[31:0]}  * {32'd0, uc[63:32]};
            pac8_reg[2] <= {32'd0, ua[63:32]} * {32'd0, uc[31:0]};
            pac8_reg[3] <= {32'd0, ua[63:32]} * {32'd0, uc[63:32]};
            pbb8_reg[0] <= {32'd0, ub[31:0]}  * {32'd0, ub[31:0]};
            pbb8_reg[1] <= {32'd0, ub[31:0]}  * {32'd0, ub[63:32]};
            pbb8_reg[2] <= {32'd0, ub[63:32]} * {32'd0, ub[31:0]};
            pbb8_reg[3] <= {32'd0, ub[63:32]} * {32'd0, ub[63:32]};
            nac8_reg    <= a7_reg[63] ^ c7_reg[63];
            a8_reg      <= a7_reg;
            b8_reg      <= b7_reg;

            sac9_reg <= 128'(pac8_reg[0]) + (128'(pac8_reg[1]) << 32)
                      + (128'(pac8_reg[2]) << 32) + (128'(pac8_reg[3]) << 64);
            sbb9_reg <= 128'(pbb8_reg[0]) + (128'(pbb8_reg[1]) << 32)
                      + (128'(pbb8_reg[2]) << 32) + (128'(pbb8_reg[3]) << 64);
            nac9_reg <= nac8_reg;
            a9_reg   <= a8_reg;
            b9_reg   <= b8_reg;

            ac10_reg <= apply_sign(sac9_reg >> FRAC_BITS, nac9_reg);
            bb10_reg <= apply_sign(sbb9_reg >> FRAC_BITS, 1'b0);
            a10_reg  <= a9_reg;
            b10_reg  <= b9_reg;
        end
    end

    // stages 11 and 12: discriminant, then load the root extractor
    logic signed [63:0] ac11_reg, bb11_reg, a11_reg, b11_reg;
    logic signed [63:0] disc;

    assign disc = clamp66(sx(bb11_reg) - sx(ac11_reg));

    logic [RW-1:0]         sq_rem_reg [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sq_r_reg   [0:SQRT_STEPS];
    logic signed [63:0]    sq_a_reg   [0:SQRT_STEPS];
    logic signed [63:0]    sq_b_reg   [0:SQRT_STEPS];
    logic                  sq_ok_reg  [0:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac11_reg      <= clamp66($signed({ac10_reg, 2'b00}));
            bb11_reg      <= bb10_reg;
            a11_reg       <= a10_reg;
            b11_reg       <= b10_reg;
            sq_rem_reg[0] <= disc[63] ? '0 : (RW'(disc) << FRAC_BITS);
            sq_r_reg[0]   <= '0;
            sq_a_reg[0]   <= a11_reg;
            sq_b_reg[0]   <= b11_reg;
            sq_ok_reg[0]  <= !disc[63] && (a11_reg != 64'sd0);
        end
    end

    // root extraction, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int I = SQRT_STEPS - 1 - k;
        logic [RW-1:0] trial;
        logic          take;

        assign trial = (RW'(sq_r_reg[k]) << (I + 1)) + (RW'(1) << (2 * I));
        assign take  = trial <= sq_rem_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k+1] <= take ? sq_rem_reg[k] - trial : sq_rem_reg[k];
                sq_r_reg[k+1]   <= take ? sq_r_reg[k] | (SQRT_STEPS'(1) << I) : sq_r_reg[k];
                sq_a_reg[k+1]   <= sq_a_reg[k];
                sq_b_reg[k+1]   <= sq_b_reg[k];
                sq_ok_reg[k+1]  <= sq_ok_reg[k];
            end
        end
    end

    // numerators and root qualification
    logic signed [63:0] n0, n1;
    logic signed [63:0] fa;

    assign fa = sq_a_reg[SQRT_STEPS];
    assign n0 = clamp66(-sx(sq_b_reg[SQRT_STEPS])
                        - $signed({18'd0, sq_r_reg[SQRT_STEPS]}));
    assign n1 = clamp66(-sx(sq_b_reg[SQRT_STEPS])
                        + $signed({18'd0, sq_r_reg[SQRT_STEPS]}));

    logic [RW-1:0]        dv_rem0_reg [0:DIV_STEPS];
    logic [RW-1:0]        dv_rem1_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_q0_reg   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_q1_reg   [0:DIV_STEPS];
    logic [63:0]          dv_den_reg  [0:DIV_STEPS];
    logic                 dv_ok0_reg  [0:DIV_STEPS];
    logic                 dv_ok1_reg  [0:DIV_STEPS];

    logic [63:0] fa_mag;
    assign fa_mag = mag64(fa);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem0_reg[0] <= RW'(mag64(n0)) << FRAC_BITS;
            dv_rem1_reg[0] <= RW'(mag64(n1)) << FRAC_BITS;
            dv_q0_reg[0]   <= '0;
            dv_q1_reg[0]   <= '0;
            dv_den_reg[0]  <= {fa_mag[62:0], 1'b0};
            dv_ok0_reg[0]  <= sq_ok_reg[SQRT_STEPS]
                              && ((n0 == 64'sd0) || (n0[63] == fa[63]));
            dv_ok1_reg[0]  <= sq_ok_reg[SQRT_STEPS]
                              && ((n1 == 64'sd0) || (n1[63] == fa[63]));
        end
    end

    // two restoring dividers side by side, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int I = DIV_STEPS - 1 - k;
        logic [RW-1:0] dsh;
        logic          take0, take1;

        assign dsh   = RW'(dv_den_reg[k]) << I;
        assign take0 = dsh <= dv_rem0_reg[k];
        assign take1 = dsh <= dv_rem1_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem0_reg[k+1] <= take0 ? dv_rem0_reg[k] - dsh : dv_rem0_reg[k];
                dv_rem1_reg[k+1] <= take1 ? dv_rem1_reg[k] - dsh : dv_rem1_reg[k];
                dv_q0_reg[k+1]   <= take0 ? dv_q0_reg[k] | (DIV_STEPS'(1) << I) : dv_q0_reg[k];
                dv_q1_reg[k+1]   <= take1 ? dv_q1_reg[k] | (DIV_STEPS'(1) << I) : dv_q1_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_ok0_reg[k+1]  <= dv_ok0_reg[k];
                dv_ok1_reg[k+1]  <= dv_ok1_reg[k];
            end
        end
    end

    // pick the nearer qualifying root into the output register
    logic                 ok0, ok1;
    logic [DIV_STEPS-1:0] q0, q1;
    logic [DIV_STEPS-1:0] dist_next;
    logic                 hit_next;
    logic                 hit_reg;
    logic [DIV_STEPS-1:0] dist_reg;

    assign ok0 = dv_ok0_reg[DIV_STEPS];
    assign ok1 = dv_ok1_reg[DIV_STEPS];
    assign q0  = dv_q0_reg[DIV_STEPS];
    assign q1  = dv_q1_reg[DIV_STEPS];

    always_comb
    begin
        hit_next = ok0 || ok1;
        if (ok0 && ok1)
            dist_next = (q1 < q0) ? q1 : q0;
        else if (ok0)
            dist_next = q0;
        else if (ok1)
            dist_next = q1;
        else
            dist_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign hit      = hit_reg;
    assign distance = dist_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> distance == '0)
        else $error("miss reported with a non-zero distance");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !en |=> out_valid && $stable(hit) && $stable(distance))
        else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

// ===== sv/ray_cone_intersect.sv =====
// Ray / double-cone intersection: one ray in, one hit flag and distance out.
// Channels: s_* carries rays, m_* carries results, APB sets apex and slope.
// A ray may be accepted every cycle unless a result waits with m_tready low,
// so throughput is one item per cycle without back-pressure. Most of the
// depth is in the 48-stage square-root pipeline and the 31-stage root dividers.
// Registers: 0x0 apex_x, 0x4 apex_y, 0x8 apex_z, 0xC slope_factor (Q16.16).
// Write configuration only with no item in flight.
// Reset clears every valid bit, sets the apex to zero and the slope to 1.0.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; no item is lost or repeated.
// Depends on rci_pkg and rci_core.
`default_nettype none

module ray_cone_intersect
    import rci_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit, distance
    output logic      [31:0]  m_tdata
);

    cone_t cone_reg;
    logic  en;
    logic  hit;
    logic [DIV_STEPS-1:0] distance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cone_reg.apex_x       <= '0;
            cone_reg.apex_y       <= '0;
            cone_reg.apex_z       <= '0;
            cone_reg.slope_factor <= 32'(1) << FRAC_BITS;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_APEX_X: cone_reg.apex_x       <= $signed(pwdata);
                REG_APEX_Y: cone_reg.apex_y       <= $signed(pwdata);
                REG_APEX_Z: cone_reg.apex_z       <= $signed(pwdata);
                REG_SLOPE:  cone_reg.slope_factor <= pwdata;
                default:    cone_reg.slope_factor <= cone_reg.slope_factor;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_APEX_X: prdata = cone_reg.apex_x;
            REG_APEX_Y: prdata = cone_reg.apex_y;
            REG_APEX_Z: prdata = cone_reg.apex_z;
            REG_SLOPE:  prdata = cone_reg.slope_factor;
            default:    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tdata  = {distance, hit};

    rci_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .ray       (ray_t'(s_tdata)),
        .cone      (cone_reg),
        .out_valid (m_tvalid),
        .hit       (hit),
        .distance  (distance)
    );

endmodule

`default_nettype wire
